>>> hw/rtl/rat_pkg.sv
// ============================================================================
// Range address translation table: shared package
// Field widths, result status codes and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rat_pkg;

  // Field widths of one transaction.
  localparam int unsigned AddrW    = 64;
  localparam int unsigned QlenW    = 32;
  localparam int unsigned InDataW  = 224;
  localparam int unsigned OutDataW = 64;

  // Width of one stored region: start, length and physical base.
  localparam int unsigned RegionW  = 3 * AddrW;

  // Operation selector carried in the input tuser.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Result status carried in the output tuser.
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_EXISTS = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming transaction and clear the scan state
    logic scan;    // walk the table one entry per cycle
    logic finish;  // produce the result and commit an insert
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every entry has been checked
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/range_address_translation_table_unit.sv
// The table is walked one entry per cycle through a single read port of the
// region memory, each entry checked in the cycle after its read. One
// transaction is in flight at a time, from capture through the walk to the
// output register; a new transaction is taken while the previous result
// still waits in the output register.
// Reset: asynchronous, active low; the table comes up empty, no clearing pass.
// ============================================================================
// Range address translation table: top level
// Stream front end around the controller and the datapath. Inserts regions
// and translates logical addresses through the lowest-start overlapping region.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module range_address_translation_table_unit
  import rat_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Fields from bit 0: logical_address[63:0], query_length[95:64],
  // region_length[159:96], physical_base[223:160].
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // Fields from bit 0: mode.
  input  wire logic                s_axis_tuser,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // Fields from bit 0: physical_address[63:0].
  output logic      [OutDataW-1:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic      [1:0]          m_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  status_e status;

  rat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rat_dp #(
    .Entries (ENTRIES)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .in_mode_i              (s_axis_tuser),
    .in_logical_address_i   (s_axis_tdata[63:0]),
    .in_query_length_i      (s_axis_tdata[95:64]),
    .in_region_length_i     (s_axis_tdata[159:96]),
    .in_physical_base_i     (s_axis_tdata[223:160]),
    .out_status_o           (status),
    .out_physical_address_o (m_axis_tdata)
  );

  assign m_axis_tuser = status;

endmodule

`default_nettype wire

>>> hw/rtl/rat_ram.sv
// ============================================================================
// Range address translation table: generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/rat_ctrl.sv
// ============================================================================
// Range address translation table: controller
// Sequences one transaction at a time through capture, table scan and result
// delivery, and owns the valid flag of the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rat_ctrl
  import rat_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_SCAN = 3'b010,
    CS_DONE = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;
  logic        out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_vld_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_SCAN;
        end
      end
      CS_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = CS_DONE;
        end
      end
      CS_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (cmd_o.finish) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CS_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_vld_q || out_ready_i))
    else $error("result loaded over a pending result");

  // An accepted transaction always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == CS_SCAN))
    else $error("accepted transaction did not start a scan");

  // A finished scan moves on to delivery.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_SCAN && sts_i.scan_done) |=> (state_q == CS_DONE))
    else $error("scan completion lost");

endmodule

`default_nettype wire

>>> hw/rtl/rat_dp.sv
// ============================================================================
// Range address translation table: datapath
// Holds the captured transaction, the region memory and its valid bits, the
// per-entry overlap check with lowest-start selection, and the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rat_dp
  import rat_pkg::*;
#(
  parameter int unsigned Entries = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  output dp_sts_t                  sts_o,
  input  wire logic                in_mode_i,
  input  wire logic [AddrW-1:0]    in_logical_address_i,
  input  wire logic [QlenW-1:0]    in_query_length_i,
  input  wire logic [AddrW-1:0]    in_region_length_i,
  input  wire logic [AddrW-1:0]    in_physical_base_i,
  output status_e                  out_status_o,
  output logic      [AddrW-1:0]    out_physical_address_o
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);

  // Captured transaction.
  logic             mode_q;
  logic [AddrW-1:0] addr_q, end_q, rlen_q, phys_q;
  logic [AddrW:0]   end_sum;

  // Scan state.
  logic [CntW-1:0]  cnt_q;
  logic             issue;
  logic             chk_vld_q;
  logic [IdxW-1:0]  chk_idx_q;

  // Accumulated scan results.
  logic             found_q, conflict_q, free_found_q;
  logic [AddrW-1:0] best_s_q, best_off_q;
  logic [IdxW-1:0]  free_idx_q;

  // Region memory and valid bits.
  logic [Entries-1:0] vld_q;
  logic [RegionW-1:0] rdata;
  logic               we;

  // Entry under check.
  logic [AddrW-1:0] ent_s, ent_l, ent_p;
  logic [AddrW:0]   ent_end;
  logic             ent_vld, ent_ovl, cand, take_best;

  // Output register.
  status_e          status_q;
  logic [AddrW-1:0] pa_q;

  // Query end for the captured transaction, saturating at the top of the
  // address space. An insert checks the one-byte range at its start.
  assign end_sum = {1'b0, in_logical_address_i} +
                   ((in_mode_i == MODE_LOOKUP) ? (AddrW + 1)'(in_query_length_i)
                                               : (AddrW + 1)'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      addr_q <= in_logical_address_i;
      end_q  <= end_sum[AddrW] ? '1 : end_sum[AddrW-1:0];
      rlen_q <= in_region_length_i;
      phys_q <= in_physical_base_i;
    end
  end

  // Read one entry per cycle; the check runs in the cycle after the read.
  assign issue = cmd_i.scan && (cnt_q < CntW'(Entries));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      chk_vld_q <= issue;
      chk_idx_q <= cnt_q[IdxW-1:0];
    end
  end

  assign sts_o.scan_done = (cnt_q == CntW'(Entries)) && !chk_vld_q;

  rat_ram #(
    .Width (RegionW),
    .Depth (Entries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_idx_q),
    .wdata_i ({phys_q, rlen_q, addr_q}),
    .re_i    (issue),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  // Overlap check of one entry. The region end is taken exactly, one bit wider.
  assign ent_s     = rdata[AddrW-1:0];
  assign ent_l     = rdata[2*AddrW-1:AddrW];
  assign ent_p     = rdata[3*AddrW-1:2*AddrW];
  assign ent_vld   = chk_vld_q && vld_q[chk_idx_q];
  assign ent_end   = {1'b0, ent_s} + {1'b0, ent_l};
  assign ent_ovl   = (ent_s < end_q) && (ent_end > {1'b0, addr_q});
  assign cand      = ent_vld && ent_ovl;
  assign take_best = cand && (!found_q || (ent_s < best_s_q));

  // Scan result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      conflict_q   <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q      <= 1'b0;
      conflict_q   <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (take_best) begin
        found_q <= 1'b1;
      end
      if (ent_vld && (ent_ovl || (ent_s == addr_q))) begin
        conflict_q <= 1'b1;
      end
      if (chk_vld_q && !vld_q[chk_idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
      end
    end
  end

  // Best region so far, kept as its start and its physical offset.
  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_s_q   <= ent_s;
      best_off_q <= ent_p - ent_s;
    end
    if (chk_vld_q && !vld_q[chk_idx_q] && !free_found_q) begin
      free_idx_q <= chk_idx_q;
    end
  end

  // Commit of a successful insert.
  assign we = cmd_i.finish && (mode_q == MODE_INSERT) && !conflict_q && free_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[free_idx_q] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (mode_q == MODE_LOOKUP) begin
        status_q <= found_q ? STATUS_OK : STATUS_MISS;
        pa_q     <= found_q ? (addr_q + best_off_q) : '0;
      end else begin
        if (conflict_q) begin
          status_q <= STATUS_EXISTS;
        end else if (free_found_q) begin
          status_q <= STATUS_OK;
        end else begin
          status_q <= STATUS_FULL;
        end
        pa_q <= '0;
      end
    end
  end

  assign out_status_o           = status_q;
  assign out_physical_address_o = pa_q;

  // An insert only ever fills an empty slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !vld_q[free_idx_q])
    else $error("insert overwrote a valid region");

  // Each insert adds exactly one valid region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> ($countones(vld_q) == $past($countones(vld_q)) + 1))
    else $error("valid count did not grow by one on insert");

  // Entries are checked only while the controller is scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> $past(cmd_i.scan))
    else $error("entry checked outside a scan");

endmodule

`default_nettype wire

>>> dv/tb_range_address_translation_table_unit.sv
// ============================================================================
// Range address translation table: block-level testbench
// Drives insert and lookup transactions into the stream input and checks
// every result against an in-bench model of the region table, or typed rows
// against their own result. A directed table covers the edge cases, and a
// random phase follows that mostly aims lookups at stored regions, inside or
// at the edges. Both stream sides stall at random outside a steady stretch.
// ============================================================================
`timescale 1ns / 1ps

module tb_range_address_translation_table_unit;
  import rat_pkg::*;

  localparam int unsigned NumRegions  = 16;
  localparam int unsigned TotalItems  = 1950;
  localparam int unsigned DrainCycles = 4 * (NumRegions + 4);

  // One directed stimulus row; typed rows carry their own expected result.
  typedef struct {
    logic        mode;
    logic [63:0] laddr;
    logic [31:0] qlen;
    logic [63:0] rlen;
    logic [63:0] pbase;
    bit          typed;
    status_e     status;
    logic [63:0] paddr;
  } xlat_req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] paddr;
  } xlat_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  // Side information that travels with the request on the input bus.
  bit          req_typed  = 1'b0;
  status_e     req_status = STATUS_OK;
  logic [63:0] req_paddr  = '0;

  // Disables random stalls on both sides during a steady stretch.
  bit steady = 1'b0;

  // Model of the region table.
  bit          map_valid [NumRegions];
  logic [63:0] map_start [NumRegions];
  logic [63:0] map_len   [NumRegions];
  logic [63:0] map_phys  [NumRegions];

  xlat_result_t expected_xlat_q[$];
  xlat_req_t    directed_q[$];
  xlat_result_t predicted;
  xlat_result_t observed;
  int unsigned  mismatch_count = 0;

  range_address_translation_table_unit #(
    .ENTRIES(NumRegions)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The run ends here if the block stops making progress.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Returns the slot of the lowest-start region that overlaps [a, a + len),
  // or -1. The query end saturates, and the region end is taken exactly.
  function automatic int find_region(logic [63:0] a, logic [63:0] len);
    logic [63:0] e;
    logic [64:0] region_end;
    int          best;
    e    = a + len;
    best = -1;
    if (e < a) begin
      e = '1;
    end
    for (int i = 0; i < NumRegions; i++) begin
      region_end = {1'b0, map_start[i]} + {1'b0, map_len[i]};
      if (map_valid[i] && map_start[i] < e && {1'b0, a} < region_end) begin
        if (best < 0 || map_start[i] < map_start[best]) begin
          best = i;
        end
      end
    end
    return best;
  endfunction

  // Computes the result of one request and applies an insert to the model.
  function automatic xlat_result_t translate(logic mode, logic [63:0] laddr,
                                             logic [31:0] qlen, logic [63:0] rlen,
                                             logic [63:0] pbase);
    xlat_result_t res;
    int           slot;
    res  = '{STATUS_OK, 64'd0};
    if (mode == MODE_LOOKUP) begin
      slot = find_region(laddr, {32'd0, qlen});
      if (slot < 0) begin
        res.status = STATUS_MISS;
      end else begin
        res.paddr = laddr - map_start[slot] + map_phys[slot];
      end
      return res;
    end
    // An insert collides with a region holding its start or sharing it.
    if (find_region(laddr, 64'd1) >= 0) begin
      res.status = STATUS_EXISTS;
      return res;
    end
    for (int i = 0; i < NumRegions; i++) begin
      if (map_valid[i] && map_start[i] == laddr) begin
        res.status = STATUS_EXISTS;
        return res;
      end
    end
    for (int i = 0; i < NumRegions; i++) begin
      if (!map_valid[i]) begin
        map_valid[i] = 1'b1;
        map_start[i] = laddr;
        map_len[i]   = rlen;
        map_phys[i]  = pbase;
        return res;
      end
    end
    res.status = STATUS_FULL;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_row(input logic mode, input logic [63:0] laddr,
                         input logic [31:0] qlen, input logic [63:0] rlen,
                         input logic [63:0] pbase, input bit typed,
                         input status_e status, input logic [63:0] paddr);
    directed_q.push_back('{mode, laddr, qlen, rlen, pbase, typed, status, paddr});
  endtask

  // Presents one request and holds it until the block takes it.
  task automatic drive_request(input xlat_req_t req);
    while (!steady && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.mode;
    s_axis_tdata  <= {req.pbase, req.rlen, req.qlen, req.laddr};
    req_typed     <= req.typed;
    req_status    <= req.status;
    req_paddr     <= req.paddr;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
  endtask

  // Builds a random request, mostly aimed at stored regions, inside or at their edges.
  function automatic xlat_req_t random_request();
    xlat_req_t req;
    int        j;
    req       = '{MODE_LOOKUP, rand64(), $urandom, rand64(), rand64(), 1'b0,
                  STATUS_OK, 64'd0};
    j         = $urandom_range(0, NumRegions - 1);
    if ($urandom_range(0, 99) < 25) begin
      req.mode = MODE_INSERT;
      if (map_valid[j] && $urandom_range(0, 1) == 1) begin
        req.laddr = map_start[j] + 64'($urandom_range(0, 16)) - 64'd8;
      end
      case ($urandom_range(0, 3))
        0: req.rlen = 64'($urandom_range(0, 256));
        1: req.rlen = '1;
        2: req.rlen = '0;
        default: ;
      endcase
      return req;
    end
    if (map_valid[j]) begin
      case ($urandom_range(0, 4))
        0: req.laddr = map_start[j] + 64'($urandom_range(0, 16)) - 64'd8;
        1: req.laddr = map_start[j] + map_len[j] + 64'($urandom_range(0, 16)) - 64'd8;
        2, 3: req.laddr = map_start[j] + (rand64() & map_len[j]);
        default: ;
      endcase
    end
    case ($urandom_range(0, 3))
      0: req.qlen = '0;
      1: req.qlen = 32'($urandom_range(1, 64));
      2: req.qlen = '1;
      default: ;
    endcase
    return req;
  endfunction

  // Output side: outside a steady stretch, ready drops at random with a chance of about 30 percent.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // Every accepted request yields one expected result.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted = translate(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[95:64],
                            s_axis_tdata[159:96], s_axis_tdata[223:160]);
      if (req_typed) begin
        predicted = '{req_status, req_paddr};
      end
      expected_xlat_q.push_back(predicted);
    end
  end

  // Every accepted result is compared with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_xlat_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d paddr %h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        observed = expected_xlat_q.pop_front();
        if (m_axis_tuser != observed.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    m_axis_tuser, observed.status));
        end
        if (m_axis_tdata != observed.paddr) begin
          report_mismatch($sformatf("physical_address %h, expected %h",
                                    m_axis_tdata, observed.paddr));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    for (int i = 0; i < NumRegions; i++) begin
      map_valid[i] = 1'b0;
      map_start[i] = '0;
      map_len[i]   = '0;
      map_phys[i]  = '0;
    end

    // Directed cases: empty table, conflicts, exclusive ends, zero-length
    // and wrapping regions, lowest-start pick, then a full table.
    add_row(MODE_LOOKUP, 64'h0, 32'h0, '0, '0, 1'b1, STATUS_MISS, '0);
    add_row(MODE_LOOKUP, '1, '1, '1, '1, 1'b1, STATUS_MISS, '0);
    add_row(MODE_INSERT, 64'h1000, '0, 64'h100, 64'h8000_0000, 1'b1, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'h1000, '0, 64'h0, 64'h0, 1'b1, STATUS_EXISTS, '0);
    add_row(MODE_INSERT, 64'h10FF, '0, 64'h1, 64'h0, 1'b1, STATUS_EXISTS, '0);
    add_row(MODE_LOOKUP, 64'h1010, 32'h0, '0, '0, 1'b0, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'h1100, '0, 64'h10, 64'h100, 1'b1, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'h2000, '0, 64'h0, 64'hDEAD_0000, 1'b1, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'h2000, '0, 64'h5, 64'h0, 1'b1, STATUS_EXISTS, '0);
    add_row(MODE_LOOKUP, 64'h1FFF, 32'h2, '0, '0, 1'b0, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FF00, '0, '1, '1, 1'b1, STATUS_OK, '0);
    add_row(MODE_LOOKUP, '1, '1, '0, '0, 1'b0, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'h0, '0, 64'h10, 64'h0, 1'b1, STATUS_OK, '0);
    add_row(MODE_LOOKUP, 64'h0, '1, '0, '0, 1'b0, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'h5000, '0, 64'h100, 64'h5_0000, 1'b1, STATUS_OK, '0);
    add_row(MODE_INSERT, 64'h4000, '0, 64'h1_0000, 64'h4_0000, 1'b1, STATUS_OK, '0);
    add_row(MODE_LOOKUP, 64'h5010, 32'h10, '0, '0, 1'b0, STATUS_OK, '0);
    add_row(MODE_LOOKUP, 64'h3FFF, 32'h1, '0, '0, 1'b1, STATUS_MISS, '0);
    // Fill the remaining slots with widely spaced regions.
    for (int k = 1; k <= 9; k++) begin
      add_row(MODE_INSERT, 64'(k) << 36, '0, 64'd1 << (4 * k),
              (64'(k) << 60) | 64'h0ABC_DEF0, 1'b1, STATUS_OK, '0);
    end
    add_row(MODE_INSERT, 64'h7777_0000_0000, '0, 64'h1, 64'h0, 1'b1, STATUS_FULL, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      drive_request(directed_q[i]);
    end

    random_items = TotalItems - directed_q.size();
    for (int unsigned n = 0; n < random_items; n++) begin
      steady <= (n >= 700 && n < 1000);
      drive_request(random_request());
    end
    s_axis_tvalid <= 1'b0;
    steady        <= 1'b0;

    // Drain the outstanding results, then wait a further margin before the verdict.
    while (expected_xlat_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
